// ===== rtl/pps_pkg.sv =====
package pps_pkg;

    localparam int VW = 44;
    localparam int ZW = 22;
    localparam int SW = 24;
    localparam int DW = 16;
    localparam int AW = 15;

    localparam logic signed [ZW-1:0] ANG_PI   = 22'sd411775;
    localparam logic signed [ZW-1:0] ANG_PI_2 = 22'sd205887;
    localparam logic signed [VW-1:0] SIN_GAIN = 44'sd636751;

    typedef enum logic [2:0] {
        REG_WHEEL_BASE     = 3'd0,
        REG_LOOKAHEAD_GAIN = 3'd1,
        REG_BASE_LOOKAHEAD = 3'd2,
        REG_STEER_MIN      = 3'd3,
        REG_STEER_MAX      = 3'd4
    } t_reg;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [DW-1:0]        lf;
        logic                 zf;
        logic                 npos;
        logic                 nneg;
    } t_pl;

    function automatic logic signed [ZW-1:0] atan_tab(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:  v = 22'sd102944;
            1:  v = 22'sd60771;
            2:  v = 22'sd32110;
            3:  v = 22'sd16299;
            4:  v = 22'sd8181;
            5:  v = 22'sd4095;
            6:  v = 22'sd2048;
            7:  v = 22'sd1024;
            8:  v = 22'sd512;
            9:  v = 22'sd256;
            10: v = 22'sd128;
            11: v = 22'sd64;
            12: v = 22'sd32;
            13: v = 22'sd16;
            14: v = 22'sd8;
            15: v = 22'sd4;
            16: v = 22'sd2;
            17: v = 22'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic t_pl vec_iter(input t_pl p, input int i);
        t_pl r;
        r = p;
        if (!p.y[VW-1]) begin
            r.x = p.x + (p.y >>> i);
            r.y = p.y - (p.x >>> i);
            r.z = p.z + atan_tab(i);
        end else begin
            r.x = p.x - (p.y >>> i);
            r.y = p.y + (p.x >>> i);
            r.z = p.z - atan_tab(i);
        end
        return r;
    endfunction

    function automatic t_pl rot_iter(input t_pl p, input int i);
        t_pl r;
        r = p;
        if (!p.z[ZW-1]) begin
            r.x = p.x - (p.y >>> i);
            r.y = p.y + (p.x >>> i);
            r.z = p.z - atan_tab(i);
        end else begin
            r.x = p.x + (p.y >>> i);
            r.y = p.y - (p.x >>> i);
            r.z = p.z + atan_tab(i);
        end
        return r;
    endfunction

endpackage

// ===== rtl/pps_if.sv =====
interface pps_in_if;
    logic                 valid;
    logic                 ready;
    logic signed [15:0]   target_x;
    logic signed [15:0]   target_y;
    logic [15:0]          speed;
    modport source (output valid, target_x, target_y, speed, input ready);
    modport sink   (input valid, target_x, target_y, speed, output ready);
endinterface

interface pps_out_if;
    logic                 valid;
    logic                 ready;
    logic signed [14:0]   steer_angle;
    modport source (output valid, steer_angle, input ready);
    modport sink   (input valid, steer_angle, output ready);
endinterface

// ===== rtl/pure_pursuit_steering_unit.sv =====
// Stages: A, B, heading vectoring, C, sine rotation, D, E, steering vectoring, F.
// Throughput: one transaction per cycle unless the result stalls; each CORDIC
// iteration is its own stage. A stalled result holds the whole pipeline in place.
// Reset (i_rst_n, synchronous, active low) clears all valid bits and loads
// the register defaults.
module pure_pursuit_steering_unit #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pps_in_if.sink      i_item,
    pps_out_if.source   o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int N = CORDIC_ITERATIONS;

    logic [15:0]            r_wb, r_gain, r_base;
    logic signed [14:0]     r_smin, r_smax;
    logic                   en;
    pps_pkg::t_reg          widx;

    assign widx   = pps_pkg::t_reg'(paddr[4:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb   <= 16'd812;
            r_gain <= 16'd230;
            r_base <= 16'd2560;
            r_smin <= -15'sd4284;
            r_smax <= 15'sd4284;
        end else if (psel && penable && pwrite) begin
            unique case (widx)
                pps_pkg::REG_WHEEL_BASE:     r_wb   <= pwdata[15:0];
                pps_pkg::REG_LOOKAHEAD_GAIN: r_gain <= pwdata[15:0];
                pps_pkg::REG_BASE_LOOKAHEAD: r_base <= pwdata[15:0];
                pps_pkg::REG_STEER_MIN:      r_smin <= pwdata[14:0];
                pps_pkg::REG_STEER_MAX:      r_smax <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (widx)
            pps_pkg::REG_WHEEL_BASE:     prdata = {16'd0, r_wb};
            pps_pkg::REG_LOOKAHEAD_GAIN: prdata = {16'd0, r_gain};
            pps_pkg::REG_BASE_LOOKAHEAD: prdata = {16'd0, r_base};
            pps_pkg::REG_STEER_MIN:      prdata = {17'd0, r_smin};
            pps_pkg::REG_STEER_MAX:      prdata = {17'd0, r_smax};
            default:                     prdata = '0;
        endcase
    end

    logic                   r_f_v;
    assign en           = !r_f_v || o_result.ready;
    assign i_item.ready = en;

    // stage A: offset and lookahead product
    logic                   r_a_v;
    logic signed [17:0]     r_a_dx;
    logic signed [15:0]     r_a_ty;
    logic [31:0]            r_a_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_v <= 1'b0;
        else if (en)  r_a_v <= i_item.valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_dx   <= 18'(i_item.target_x) - $signed({2'b00, r_wb});
            r_a_ty   <= i_item.target_y;
            r_a_prod <= r_gain * i_item.speed;
        end
    end

    // stage B: fold to right half plane, finish lookahead
    logic                   r_b_v;
    pps_pkg::t_pl           r_b, n_b;
    logic [25:0]            lf_sum;
    logic signed [pps_pkg::VW-1:0] bx, by;

    always_comb begin
        lf_sum = 26'((33'(r_a_prod) + 33'd128) >> 8) + 26'(r_base);
        bx     = pps_pkg::VW'(r_a_dx) <<< 20;
        by     = pps_pkg::VW'(r_a_ty) <<< 20;
        n_b    = '0;
        n_b.lf = (lf_sum > 26'd65535) ? 16'hFFFF : lf_sum[15:0];
        n_b.zf = (r_a_dx == '0) && (r_a_ty == '0);
        if (r_a_dx[17]) begin
            n_b.x = -bx;
            n_b.y = -by;
            n_b.z = r_a_ty[15] ? -pps_pkg::ANG_PI : pps_pkg::ANG_PI;
        end else begin
            n_b.x = bx;
            n_b.y = by;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_v <= 1'b0;
        else if (en)  r_b_v <= r_a_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) r_b <= n_b;
    end

    // heading error vectoring chain
    pps_pkg::t_pl           r_v1 [N];
    logic [N-1:0]           r_v1_v;

    for (genvar k = 0; k < N; k++) begin : g_v1
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v1_v[k] <= 1'b0;
            else if (en)  r_v1_v[k] <= (k == 0) ? r_b_v : r_v1_v[(k == 0) ? 0 : k-1];
        end
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (en) r_v1[k] <= pps_pkg::vec_iter(r_b, k);
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (en) r_v1[k] <= pps_pkg::vec_iter(r_v1[k-1], k);
            end
        end
    end

    // stage C: clamp alpha, seed sine rotation
    logic                   r_c_v;
    pps_pkg::t_pl           r_c, n_c;
    logic signed [pps_pkg::ZW-1:0] alpha;

    always_comb begin
        alpha = r_v1[N-1].zf ? '0 : r_v1[N-1].z;
        if (alpha > pps_pkg::ANG_PI_2)  alpha = pps_pkg::ANG_PI_2;
        if (alpha < -pps_pkg::ANG_PI_2) alpha = -pps_pkg::ANG_PI_2;
        n_c    = '0;
        n_c.x  = pps_pkg::SIN_GAIN;
        n_c.z  = alpha;
        n_c.lf = r_v1[N-1].lf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c_v <= 1'b0;
        else if (en)  r_c_v <= r_v1_v[N-1];
    end

    always_ff @(posedge i_clk) begin
        if (en) r_c <= n_c;
    end

    // sine rotation chain
    pps_pkg::t_pl           r_s [N];
    logic [N-1:0]           r_s_v;

    for (genvar k = 0; k < N; k++) begin : g_s
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_s_v[k] <= 1'b0;
            else if (en)  r_s_v[k] <= (k == 0) ? r_c_v : r_s_v[(k == 0) ? 0 : k-1];
        end
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (en) r_s[k] <= pps_pkg::rot_iter(r_c, k);
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (en) r_s[k] <= pps_pkg::rot_iter(r_s[k-1], k);
            end
        end
    end

    // stage D: numerator 2 * wb * sin
    logic                   r_d_v;
    logic signed [pps_pkg::VW-1:0] r_d_num;
    logic [15:0]            r_d_lf;
    logic signed [40:0]     prod_n;

    assign prod_n = $signed({1'b0, r_wb}) * $signed(r_s[N-1].y[pps_pkg::SW-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d_v <= 1'b0;
        else if (en)  r_d_v <= r_s_v[N-1];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_num <= pps_pkg::VW'(prod_n) <<< 1;
            r_d_lf  <= r_s[N-1].lf;
        end
    end

    // stage E: seed steering vectoring
    logic                   r_e_v;
    pps_pkg::t_pl           r_e, n_e;

    always_comb begin
        n_e      = '0;
        n_e.x    = pps_pkg::VW'({r_d_lf, 20'd0});
        n_e.y    = r_d_num;
        n_e.lf   = r_d_lf;
        n_e.zf   = (r_d_lf == '0);
        n_e.npos = !r_d_num[pps_pkg::VW-1] && (r_d_num != '0);
        n_e.nneg = r_d_num[pps_pkg::VW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_e_v <= 1'b0;
        else if (en)  r_e_v <= r_d_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) r_e <= n_e;
    end

    // steering vectoring chain
    pps_pkg::t_pl           r_v2 [N];
    logic [N-1:0]           r_v2_v;

    for (genvar k = 0; k < N; k++) begin : g_v2
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v2_v[k] <= 1'b0;
            else if (en)  r_v2_v[k] <= (k == 0) ? r_e_v : r_v2_v[(k == 0) ? 0 : k-1];
        end
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (en) r_v2[k] <= pps_pkg::vec_iter(r_e, k);
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (en) r_v2[k] <= pps_pkg::vec_iter(r_v2[k-1], k);
            end
        end
    end

    // stage F: unit conversion, limit clamp, output register
    logic signed [pps_pkg::ZW-1:0] dlt, dout, lo, hi;
    logic signed [14:0]     r_f_steer;

    always_comb begin
        priority if (!r_v2[N-1].zf) dlt = r_v2[N-1].z;
        else if (r_v2[N-1].npos)    dlt = pps_pkg::ANG_PI_2;
        else if (r_v2[N-1].nneg)    dlt = -pps_pkg::ANG_PI_2;
        else                        dlt = '0;
        dout = (dlt + 22'sd8) >>> 4;
        lo   = pps_pkg::ZW'(r_smin);
        hi   = pps_pkg::ZW'(r_smax);
        if (dout > hi) dout = hi;
        if (dout < lo) dout = lo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_f_v <= 1'b0;
        else if (en)  r_f_v <= r_v2_v[N-1];
    end

    always_ff @(posedge i_clk) begin
        if (en) r_f_steer <= dout[14:0];
    end

    assign o_result.valid       = r_f_v;
    assign o_result.steer_angle = r_f_steer;

endmodule

// ===== rtl/pps_chk.sv =====
module pps_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [14:0] i_out_steer
);
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input taken while result stalled");

    a_flow_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid || i_out_ready |-> i_in_ready)
        else $error("input blocked while pipeline free");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_steer))
        else $error("stalled result changed");
endmodule

bind pure_pursuit_steering_unit pps_chk u_pps_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_steer (o_result.steer_angle)
);
